/* sv/dnlc_pkg.sv */
package dnlc_pkg;

  // Operating modes, as written to the operating_mode register.
  typedef enum logic [1:0] {
    OP_AUTO  = 2'd0,
    OP_TIMED = 2'd1,
    OP_NIGHT = 2'd2,
    OP_DAY   = 2'd3
  } op_mode_e;

  // Last mode entered; PM_NONE differs from every operating mode.
  typedef enum logic [2:0] {
    PM_AUTO  = 3'd0,
    PM_TIMED = 3'd1,
    PM_NIGHT = 3'd2,
    PM_DAY   = 3'd3,
    PM_NONE  = 3'd4
  } prev_mode_e;

  // Installed lamps.
  typedef enum logic [1:0] {
    LM_NONE  = 2'd0,
    LM_IR    = 2'd1,
    LM_WHITE = 2'd2,
    LM_DUAL  = 2'd3
  } lamp_mode_e;

  // Controller phase.
  typedef enum logic [1:0] {
    PH_DAY   = 2'd0,
    PH_IR    = 2'd1,
    PH_WHITE = 2'd2
  } phase_e;

  // Active lamp as reported on lamp_state.
  typedef enum logic [1:0] {
    LS_NONE  = 2'd0,
    LS_IR    = 2'd1,
    LS_WHITE = 2'd2
  } lamp_state_e;

  // Profile reload request.
  typedef enum logic [1:0] {
    RL_NONE = 2'd0,
    RL_IR   = 2'd1,
    RL_VIS  = 2'd2
  } reload_e;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_OP_MODE     = 3'd0,
    CFG_LAMP_MODE   = 3'd1,
    CFG_STRENGTH    = 3'd2,
    CFG_NIGHT_START = 3'd3,
    CFG_DAY_START   = 3'd4,
    CFG_WHITE_HOLD  = 3'd5,
    CFG_IR_HOLD     = 3'd6
  } cfg_idx_e;

  // Loaded image profile codes.
  localparam logic [1:0] PROF_IR  = 2'd0;
  localparam logic [1:0] PROF_VIS = 2'd1;

  localparam int unsigned TodW   = 17;
  localparam int unsigned SecW   = 32;
  localparam int unsigned LevelW = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 17;
  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 24;

  localparam logic [LevelW-1:0] HoldReset = 8'd10;

  // Drive registers.
  typedef struct packed {
    logic              filter;
    logic              mono;
    logic [LevelW-1:0] ir;
    logic [LevelW-1:0] white;
    lamp_state_e       lamp;
  } drive_t;

  // One result item, laid out as on the output tdata (lowest field last).
  typedef struct packed {
    logic              window_error;
    logic              drive_written;
    reload_e           reload_profile;
    lamp_state_e       lamp_state;
    logic [LevelW-1:0] white_level;
    logic [LevelW-1:0] ir_level;
    logic              mono_mode;
    logic              ircut_open;
  } result_t;

endpackage

/* sv/day_night_lamp_controller.sv */
// Day/night lamp controller for a camera.
// Input stream (s_axis_*): one transfer per poll, carrying the light flag,
// the person flag, monotonic seconds, the time of day, the loaded profile
// and a settings-changed pulse. Output stream (m_axis_*): one result per
// poll with the drive registers, a profile reload request, a drive-written
// flag and a window error flag.
// Configuration (cfg_*): write the register at cfg_index_i with cfg_data_i;
// cfg_ready_o is always high. Writes belong to idle periods only.
// Each result is registered in the output register, and a new poll is taken
// every cycle while s_axis_tready is high: the whole decision is one pass of
// logic with one 32-bit age subtract, followed by the output register.
// A skid register behind the output register keeps accepting one more poll
// while the receiver stalls; with both full, s_axis_tready drops until the
// receiver takes a result. Results always leave in poll order.
// Reset clears the state and the output stage and loads the register
// defaults (always-day mode, no lamp, hold times of ten seconds). The first
// poll after reset restarts the controller in the day phase.
module day_night_lamp_controller (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Fields from bit 0: daylight, person_present, now_seconds[31:0],
  // time_of_day[16:0], loaded_profile[1:0], settings_changed, two zero bits.
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [dnlc_pkg::InDataW-1:0]   s_axis_tdata,
  // Fields from bit 0: ircut_open, mono_mode, ir_level[7:0],
  // white_level[7:0], lamp_state[1:0], reload_profile[1:0], drive_written,
  // window_error.
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [dnlc_pkg::OutDataW-1:0]  m_axis_tdata,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [dnlc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [dnlc_pkg::CfgDataW-1:0]  cfg_data_i
);
  import dnlc_pkg::*;

  // Configuration registers.
  op_mode_e          op_mode_q;
  lamp_mode_e        lamp_mode_q;
  logic [LevelW-1:0] strength_q;
  logic [TodW-1:0]   night_start_q;
  logic [TodW-1:0]   day_start_q;
  logic [LevelW-1:0] white_hold_q;
  logic [LevelW-1:0] ir_hold_q;

  // Controller state.
  phase_e            phase_q, phase_d;
  prev_mode_e        prev_q, prev_d;
  logic              started_q;
  logic [SecW-1:0]   pstart_q, pstart_d;
  drive_t            drv_q, drv_d;

  // Output stage.
  result_t           out_q, skid_q, res_d;
  logic              out_valid_q, skid_valid_q;

  // Input fields.
  logic              in_day, in_person, in_chg;
  logic [SecW-1:0]   in_now;
  logic [TodW-1:0]   in_tod;
  logic [1:0]        in_prof;
  logic              in_acc;

  assign in_day    = s_axis_tdata[0];
  assign in_person = s_axis_tdata[1];
  assign in_now    = s_axis_tdata[33:2];
  assign in_tod    = s_axis_tdata[50:34];
  assign in_prof   = s_axis_tdata[52:51];
  assign in_chg    = s_axis_tdata[53];

  assign s_axis_tready = !skid_valid_q;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // Drive patterns.
  function automatic drive_t drive_day();
    drive_t d;
    d = '0;
    return d;
  endfunction

  function automatic drive_t drive_ir(input logic [LevelW-1:0] s);
    drive_t d;
    d.filter = 1'b1;
    d.mono   = 1'b1;
    d.ir     = s;
    d.white  = '0;
    d.lamp   = LS_IR;
    return d;
  endfunction

  function automatic drive_t drive_white(input drive_t cur, input logic [LevelW-1:0] s);
    drive_t d;
    d        = cur;
    d.filter = 1'b0;
    d.mono   = 1'b0;
    d.ir     = '0;
    d.white  = s;
    d.lamp   = LS_WHITE;
    return d;
  endfunction

  // Night drive depends on the lamps; dual lamps keep mono and lamp state.
  function automatic drive_t drive_night(input drive_t cur, input lamp_mode_e lm,
                                         input logic [LevelW-1:0] s);
    drive_t d;
    d = cur;
    case (lm)
      LM_IR:    d = drive_ir(s);
      LM_WHITE: d = drive_white(cur, s);
      LM_DUAL: begin
        d.filter = 1'b0;
        d.ir     = s;
        d.white  = s;
      end
      default:  d = cur;
    endcase
    return d;
  endfunction

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_mode_q     <= OP_DAY;
      lamp_mode_q   <= LM_NONE;
      strength_q    <= '0;
      night_start_q <= '0;
      day_start_q   <= '0;
      white_hold_q  <= HoldReset;
      ir_hold_q     <= HoldReset;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_OP_MODE:     op_mode_q     <= op_mode_e'(cfg_data_i[1:0]);
        CFG_LAMP_MODE:   lamp_mode_q   <= lamp_mode_e'(cfg_data_i[1:0]);
        CFG_STRENGTH:    strength_q    <= cfg_data_i[LevelW-1:0];
        CFG_NIGHT_START: night_start_q <= cfg_data_i[TodW-1:0];
        CFG_DAY_START:   day_start_q   <= cfg_data_i[TodW-1:0];
        CFG_WHITE_HOLD:  white_hold_q  <= cfg_data_i[LevelW-1:0];
        CFG_IR_HOLD:     ir_hold_q     <= cfg_data_i[LevelW-1:0];
        default: ;
      endcase
    end
  end

  // Per-poll decision: restart handling, then the mode logic.
  always_comb begin
    logic [SecW-1:0] age;
    logic            white_aged, ir_aged, is_day, wr, werr;
    reload_e         rl;

    phase_d = phase_q;
    prev_d  = prev_q;
    pstart_d = pstart_q;
    drv_d   = drv_q;
    wr      = 1'b0;
    werr    = 1'b0;
    rl      = RL_NONE;
    is_day  = 1'b0;

    // Restart on the first poll or after a settings change.
    if (!started_q || in_chg) begin
      phase_d  = PH_DAY;
      pstart_d = in_now;
      prev_d   = PM_NONE;
      drv_d.lamp = LS_NONE;
      if (in_chg) begin
        drv_d = drive_day();
        wr    = 1'b1;
        if (op_mode_q == OP_AUTO) begin
          rl = (lamp_mode_q == LM_IR || lamp_mode_q == LM_DUAL) ? RL_IR : RL_VIS;
        end
      end
    end

    // Phase age against the hold times.
    age        = in_now - pstart_d;
    white_aged = (|age[SecW-1:LevelW]) || (age[LevelW-1:0] > white_hold_q);
    ir_aged    = (|age[SecW-1:LevelW]) || (age[LevelW-1:0] > ir_hold_q);

    if (op_mode_q == OP_AUTO && lamp_mode_q != LM_NONE) begin
      if (prev_d != PM_AUTO) begin
        prev_d  = PM_AUTO;
        phase_d = PH_DAY;
      end
      if (in_day) begin
        if (phase_d == PH_DAY) begin
          drv_d = drive_day();
          wr    = 1'b1;
        end else begin
          if (lamp_mode_q == LM_DUAL) begin
            if (phase_d == PH_WHITE && white_aged) begin
              if (in_prof != PROF_IR) rl = RL_IR;
              drv_d    = drive_day();
              wr       = 1'b1;
              pstart_d = in_now;
              phase_d  = PH_DAY;
            end
          end else if (lamp_mode_q == LM_WHITE) begin
            if (in_person && phase_d == PH_WHITE) begin
              pstart_d = in_now;
            end else if (phase_d == PH_WHITE && white_aged) begin
              drv_d   = drive_day();
              wr      = 1'b1;
              phase_d = PH_DAY;
            end
          end
          if (phase_d == PH_IR && ir_aged) begin
            drv_d   = drive_day();
            wr      = 1'b1;
            phase_d = PH_DAY;
          end
        end
      end else if (lamp_mode_q == LM_DUAL) begin
        if (!in_person) begin
          if (phase_d == PH_DAY) begin
            drv_d    = drive_ir(strength_q);
            wr       = 1'b1;
            pstart_d = in_now;
            phase_d  = PH_IR;
          end else if (phase_d == PH_IR) begin
            pstart_d = in_now;
          end else if (phase_d == PH_WHITE && white_aged) begin
            if (in_prof != PROF_IR) begin
              rl    = RL_IR;
              drv_d = drive_ir(strength_q);
              wr    = 1'b1;
            end
            pstart_d = in_now;
            phase_d  = PH_IR;
          end
        end else begin
          if (in_prof != PROF_VIS) begin
            rl    = RL_VIS;
            drv_d = drive_white(drv_d, strength_q);
            wr    = 1'b1;
          end
          phase_d  = PH_WHITE;
          pstart_d = in_now;
        end
      end else if (lamp_mode_q == LM_IR) begin
        drv_d    = drive_ir(strength_q);
        wr       = 1'b1;
        pstart_d = in_now;
        phase_d  = PH_IR;
      end else begin
        drv_d    = drive_white(drv_d, strength_q);
        wr       = 1'b1;
        phase_d  = PH_WHITE;
        pstart_d = in_now;
      end
    end else if (op_mode_q == OP_TIMED) begin
      if (prev_d != PM_TIMED) begin
        prev_d  = PM_TIMED;
        phase_d = PH_DAY;
      end
      if (night_start_q == day_start_q) begin
        werr = 1'b1;
      end else begin
        if (night_start_q > day_start_q) begin
          is_day = (day_start_q <= in_tod) && (in_tod < night_start_q);
        end else begin
          is_day = (day_start_q <= in_tod) || (in_tod < night_start_q);
        end
        // In timed mode phase IR marks day and phase white marks night.
        if (phase_d != PH_IR && is_day) begin
          phase_d = PH_IR;
          drv_d   = drive_day();
          wr      = 1'b1;
        end else if (phase_d != PH_WHITE && !is_day) begin
          phase_d = PH_WHITE;
          drv_d   = drive_night(drv_d, lamp_mode_q, strength_q);
          wr      = wr || (lamp_mode_q != LM_NONE);
        end
      end
    end else if (op_mode_q == OP_NIGHT) begin
      if (prev_d != PM_NIGHT) begin
        prev_d  = PM_NIGHT;
        phase_d = PH_DAY;
        drv_d   = drive_night(drv_d, lamp_mode_q, strength_q);
        wr      = wr || (lamp_mode_q != LM_NONE);
      end
    end else if (op_mode_q == OP_DAY) begin
      if (prev_d != PM_DAY) begin
        prev_d  = PM_DAY;
        phase_d = PH_DAY;
        drv_d   = drive_day();
        wr      = 1'b1;
      end
    end

    res_d.ircut_open     = drv_d.filter;
    res_d.mono_mode      = drv_d.mono;
    res_d.ir_level       = drv_d.ir;
    res_d.white_level    = drv_d.white;
    res_d.lamp_state     = drv_d.lamp;
    res_d.reload_profile = rl;
    res_d.drive_written  = wr;
    res_d.window_error   = werr;
  end

  // State update on every input transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_DAY;
      prev_q    <= PM_NONE;
      started_q <= 1'b0;
      pstart_q  <= '0;
      drv_q     <= '0;
    end else if (in_acc) begin
      phase_q   <= phase_d;
      prev_q    <= prev_d;
      started_q <= 1'b1;
      pstart_q  <= pstart_d;
      drv_q     <= drv_d;
    end
  end

  // Output register with a skid register behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      out_valid_q  <= skid_valid_q || in_acc;
      skid_valid_q <= 1'b0;
    end else if (in_acc) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || m_axis_tready) begin
      out_q <= skid_valid_q ? skid_q : res_d;
    end else if (in_acc) begin
      skid_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  // The skid register only fills behind a held result.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register holds a result with the output register empty");

  // Every accepted poll is followed by a valid output in the next cycle.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> m_axis_tvalid)
    else $error("accepted poll produced no result");

  // The restart happens only once unless settings change.
  a_started_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> started_q)
    else $error("controller not marked started after a poll");

endmodule
